FILE: design/wtl_pkg.sv
// Shared widths, codes and reset values for the wavetable LFO.
package wtl_pkg;

	localparam int PHASE_W       = 30;
	localparam int ENV_W         = 25;
	localparam int FACTOR_W      = 26;
	localparam int RATE_W        = 16;
	localparam int SAMPLE_W      = 16;
	localparam int LEVEL_W       = 16;
	localparam int IDX_W         = 11;
	localparam int KIND_W        = 2;
	localparam int PROD_W        = RATE_W + FACTOR_W;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;
	localparam int TABLE_ADDR_BITS_DEF = 11;

	// step = (rate * factor) >> 8, only the low PHASE_W bits survive the wrap
	localparam int STEP_SHIFT    = 8;

	localparam logic [ENV_W-1:0]    ENV_ONE        = 25'h100_0000;
	localparam logic [FACTOR_W-1:0] FACTOR_RESET   = 26'd779128;
	localparam logic [ENV_W-1:0]    ATTACK_RESET   = 25'h100_0000;
	localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET  = 16'h8000;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

	// register indexes (paddr[2])
	localparam logic REG_PHASE_FACTOR = 1'b0;
	localparam logic REG_ATTACK_STEP  = 1'b1;

endpackage

FILE: design/wtl_mul.sv
// Shared unsigned multiplier with registered product.
module wtl_mul (
	input  logic                         clk,
	input  logic                         en,
	input  logic [wtl_pkg::RATE_W-1:0]   a,
	input  logic [wtl_pkg::FACTOR_W-1:0] b,
	output logic [wtl_pkg::PROD_W-1:0]   prod_q
);
	import wtl_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

endmodule

FILE: design/wtl_table.sv
// Waveform table memory: one write port, one registered read port.
module wtl_table #(
	parameter int TABLE_ADDR_BITS = wtl_pkg::TABLE_ADDR_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [TABLE_ADDR_BITS-1:0]     waddr,
	input  logic [wtl_pkg::SAMPLE_W-1:0]   wdata,
	input  logic                           re,
	input  logic [TABLE_ADDR_BITS-1:0]     raddr,
	output logic [wtl_pkg::SAMPLE_W-1:0]   rdata_q
);
	import wtl_pkg::*;

	localparam int DEPTH = 1 << TABLE_ADDR_BITS;

	logic [SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

FILE: design/wavetable_lfo_with_attack.sv
// Wavetable LFO with linear attack envelope: sequencer, registers and top level.
//
// Wavetable low-frequency oscillator. Each input transaction carries a kind:
// a load writes table_value into the waveform table at table_index, a restart
// clears the 30-bit phase and the Q1.24 attack envelope, and a sample advances
// the phase by (rate * phase_factor) >> 8 (mod 2^30), raises the envelope by
// attack_step (clamped at 1.0), reads the table at the top TABLE_ADDR_BITS
// phase bits and returns level = round(((s+1)/2)*env + (1-env)/2) in unsigned
// Q0.16. Loads and restarts return nothing; kind 3 is dropped. After it is
// accepted, a sample runs five sequencer steps: both products go through one
// 16x26 multiplier in turn, and the table read sits between them on the
// single read port. in_stall is high while a sample is in the sequencer.
// The result sits in an output register, so the next transaction is taken
// while it waits on out_stall; a second sample only holds in its last step
// until the first is taken. Table entries are undefined until loaded.
// Registers (APB, 32-bit data): 0x0 phase_factor (26 bits), 0x4 attack_step
// (25 bits); write them only while the block is idle.
module wavetable_lfo_with_attack #(
	parameter int TABLE_ADDR_BITS = wtl_pkg::TABLE_ADDR_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wtl_pkg::PADDR_W-1:0]         paddr,
	input  logic [wtl_pkg::PDATA_W-1:0]         pwdata,
	output logic [wtl_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [wtl_pkg::KIND_W-1:0]          kind,
	input  logic [wtl_pkg::RATE_W-1:0]          rate,
	input  logic [wtl_pkg::IDX_W-1:0]           table_index,
	input  logic signed [wtl_pkg::SAMPLE_W-1:0] table_value,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [wtl_pkg::LEVEL_W-1:0]         level
);
	import wtl_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,   // multiply rate * phase_factor
		ST_PHASE,  // advance phase, raise envelope
		ST_READ,   // table read at new phase
		ST_MUL,    // multiply offset sample * envelope
		ST_SUM     // add bias term, round, saturate, present
	} state_t;

	localparam int SUM_W = PROD_W;
	localparam int LVL_W = SUM_W - 24;

	state_t               state_q;
	logic [FACTOR_W-1:0]  factor_q;
	logic [ENV_W-1:0]     attack_q;
	logic [PHASE_W-1:0]   phase_q;
	logic [ENV_W-1:0]     env_q;
	logic [RATE_W-1:0]    rate_q;
	logic                 out_valid_q;
	logic [LEVEL_W-1:0]   level_q;

	logic                 in_acc;
	logic                 cfg_wr;
	logic                 mul_en;
	logic [RATE_W-1:0]    mul_a;
	logic [FACTOR_W-1:0]  mul_b;
	logic [PROD_W-1:0]    prod_q;
	logic [SAMPLE_W-1:0]  rdata_q;
	logic [SAMPLE_W-1:0]  sample_u;
	logic [TABLE_ADDR_BITS-1:0]       waddr;
	logic [TABLE_ADDR_BITS-1:0]       raddr;
	logic [IDX_W+TABLE_ADDR_BITS-1:0] idx_ext;
	logic [ENV_W:0]       env_sum;
	logic [ENV_W-1:0]     env_next;
	logic [ENV_W-1:0]     env_rest;
	logic [SUM_W-1:0]     total;
	logic [LVL_W-1:0]     lvl_wide;
	logic [LEVEL_W-1:0]   lvl_sat;
	logic                 out_free;

	// ---------------- configuration registers ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
			attack_q <= ATTACK_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_PHASE_FACTOR: factor_q <= pwdata[FACTOR_W-1:0];
				REG_ATTACK_STEP:  attack_q <= pwdata[ENV_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_PHASE_FACTOR: prdata = PDATA_W'(factor_q);
			REG_ATTACK_STEP:  prdata = PDATA_W'(attack_q);
			default:          prdata = '0;
		endcase
	end

	// ---------------- handshake ----------------
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign out_free  = ~out_valid_q | ~out_stall;

	// ---------------- shared multiplier ----------------
	// offset binary: signed sample + 32768 is the word with its top bit flipped
	assign sample_u = rdata_q ^ SAMPLE_OFFSET;
	assign mul_en   = (state_q == ST_STEP) | (state_q == ST_MUL);
	assign mul_a    = (state_q == ST_STEP) ? rate_q : sample_u;
	assign mul_b    = (state_q == ST_STEP) ? factor_q : FACTOR_W'(env_q);

	wtl_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// ---------------- waveform table ----------------
	assign idx_ext = {{TABLE_ADDR_BITS{1'b0}}, table_index};
	assign waddr   = idx_ext[TABLE_ADDR_BITS-1:0];
	assign raddr   = phase_q[PHASE_W-1 -: TABLE_ADDR_BITS];

	wtl_table #(
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_table (
		.clk     (clk),
		.we      (in_acc && (kind == KIND_LOAD)),
		.waddr   (waddr),
		.wdata   (table_value),
		.re      (state_q == ST_READ),
		.raddr   (raddr),
		.rdata_q (rdata_q)
	);

	// ---------------- envelope and output arithmetic ----------------
	assign env_sum  = {1'b0, env_q} + {1'b0, attack_q};
	assign env_next = (env_sum > {1'b0, ENV_ONE}) ? ENV_ONE : env_sum[ENV_W-1:0];
	assign env_rest = ENV_ONE - env_q;

	// u*env + (1-env)*2^15 in units of 2^-40, plus half an LSB for rounding
	assign total    = prod_q + {2'b0, env_rest, 15'b0} + SUM_W'(24'h80_0000);
	assign lvl_wide = total[SUM_W-1:24];
	assign lvl_sat  = (lvl_wide > LVL_W'({LEVEL_W{1'b1}})) ? {LEVEL_W{1'b1}}
	                                                       : lvl_wide[LEVEL_W-1:0];

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			env_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// in ST_SUM the slot is either refilled or still held
			if (out_valid_q && !out_stall && state_q != ST_SUM) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (kind == KIND_SAMPLE) begin
							state_q <= ST_STEP;
						end else if (kind == KIND_RESTART) begin
							phase_q <= '0;
							env_q   <= '0;
						end
					end
				end
				ST_STEP:  state_q <= ST_PHASE;
				ST_PHASE: begin
					phase_q <= phase_q + prod_q[STEP_SHIFT +: PHASE_W];
					env_q   <= env_next;
					state_q <= ST_READ;
				end
				ST_READ:  state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_SUM;
				ST_SUM: begin
					if (out_free) begin
						level_q     <= lvl_sat;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// rate is held for the multiply step
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rate_q <= rate;
		end
	end

`ifndef SYNTHESIS
	a_env_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= ENV_ONE)
		else $error("envelope above 1.0");

	a_out_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_SUM))
		else $error("result presented outside the final step");

	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && kind == KIND_SAMPLE) |=> (state_q == ST_STEP))
		else $error("sample transaction did not start the sequencer");

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("pending result dropped");
`endif

endmodule
